@@ hdl/gscs_pkg.sv @@
// Shared constants for the grouped sparse column sum block.
package gscs_pkg;

    localparam int SUM_W = 32;
    localparam int CFG_W = 9;

    // Command codes.
    localparam logic [1:0] CMD_ADD        = 2'd0;
    localparam logic [1:0] CMD_READ       = 2'd1;
    localparam logic [1:0] CMD_READ_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_GROUP_COUNT  = 2'd0;
    localparam logic [1:0] CFG_DROP_MISSING = 2'd1;
    localparam logic [1:0] CFG_ROW_COUNT    = 2'd2;

    localparam logic [4:0] GROUP_COUNT_RST = 5'd1;
    localparam logic [8:0] ROW_COUNT_RST   = 9'd256;

    localparam logic [SUM_W-1:0] MISSING_SUM = 32'h8000_0000;
    localparam logic [SUM_W-1:0] INT_MAX     = 32'h7FFF_FFFF;

endpackage

@@ hdl/gscs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gscs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/grouped_sparse_column_sum.sv @@
// Path: an accepted word passes the stage-one register, then the result register.
// Throughput: one word per cycle unless out_stall or the clearing pass holds in_stall;
// the sum table sits in one RAM with a registered read, and a write that meets
// the next read is forwarded. Reset: configuration returns to its defaults, then
// a clearing pass zeroes all GROUPS*ROWS entries while in_stall stays high.
module grouped_sparse_column_sum import gscs_pkg::*; #(
    parameter int ROWS   = 256,
    parameter int GROUPS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        command,
    input  logic [7:0]        row,
    input  logic [4:0]        group_code,
    input  logic signed [31:0] value,
    input  logic              unit_value,
    input  logic              last_in_column,
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [31:0] sum,
    output logic              overflow_seen,
    output logic              bad_index,
    output logic              column_done
);

    localparam int DEPTH = GROUPS * ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int GLW   = ($clog2(GROUPS + 1) > 5) ? $clog2(GROUPS + 1) : 5;
    localparam int RLW   = ($clog2(ROWS + 1) > 9) ? $clog2(ROWS + 1) : 9;

    // Configuration.
    logic [4:0] group_count_reg, group_count_next;
    logic       drop_missing_reg, drop_missing_next;
    logic [8:0] row_count_reg, row_count_next;

    // Clearing pass.
    logic          clearing_reg, clearing_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    // Stage one: the word whose RAM read is in flight.
    logic             s1_valid_reg, s1_valid_next;
    logic [1:0]       s1_cmd_reg, s1_cmd_next;
    logic             s1_bad_reg, s1_bad_next;
    logic [AW-1:0]    s1_addr_reg, s1_addr_next;
    logic [SUM_W-1:0] s1_value_reg, s1_value_next;
    logic             s1_unit_reg, s1_unit_next;
    logic             s1_last_reg, s1_last_next;
    logic             fwd_hit_reg, fwd_hit_next;
    logic [SUM_W-1:0] fwd_data_reg, fwd_data_next;

    logic ovf_flag_reg, ovf_flag_next;

    // Result register.
    logic             out_valid_reg, out_valid_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             ovf_out_reg, ovf_out_next;
    logic             bad_out_reg, bad_out_next;
    logic             done_reg, done_next;

    logic             out_free, s1_go, in_acc;
    logic [GLW-1:0]   glim, g_eff, g_m1;
    logic [RLW-1:0]   rlim;
    logic             in_bad;
    logic [AW-1:0]    in_addr;
    logic [SUM_W-1:0] ram_rdata, cur;
    logic [SUM_W-1:0] addend;
    logic [SUM_W:0]   add_full;
    logic             wr_en;
    logic [SUM_W-1:0] wr_data;
    logic [SUM_W-1:0] res_sum;
    logic             res_ovf;
    logic             flag_after;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [SUM_W-1:0] mem_wdata;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && out_free;
    assign in_stall = clearing_reg || (s1_valid_reg && !out_free);
    assign in_acc   = in_valid && !in_stall;

    // Index decode on the incoming word.
    always_comb
    begin
        glim = (GLW'(group_count_reg) > GLW'(GROUPS)) ? GLW'(GROUPS) : GLW'(group_count_reg);
        rlim = (RLW'(row_count_reg) > RLW'(ROWS)) ? RLW'(ROWS) : RLW'(row_count_reg);
        g_eff = (group_code == 5'd0) ? glim : GLW'(group_code);
        g_m1  = g_eff - GLW'(1);
        in_bad = (RLW'(row) >= rlim) || (g_eff == '0) || (g_eff > glim);
        in_addr = AW'(int'(g_m1) * ROWS + int'(row));
    end

    gscs_ram #(
        .WIDTH (SUM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (in_acc),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // Read-modify-write of the addressed entry.
    always_comb
    begin
        cur      = fwd_hit_reg ? fwd_data_reg : ram_rdata;
        addend   = s1_unit_reg ? 32'd1 : s1_value_reg;
        add_full = {cur[SUM_W-1], cur} + {addend[SUM_W-1], addend};
        wr_en      = 1'b0;
        wr_data    = cur;
        res_sum    = cur;
        flag_after = ovf_flag_reg;
        res_ovf    = ovf_flag_reg;
        if (s1_bad_reg)
        begin
            res_sum = '0;
        end
        else
        begin
            unique case (s1_cmd_reg)
                CMD_ADD:
                begin
                    if (cur != MISSING_SUM)
                    begin
                        wr_en = 1'b1;
                        if (!s1_unit_reg && s1_value_reg == MISSING_SUM)
                        begin
                            if (!drop_missing_reg)
                            begin
                                wr_data = MISSING_SUM;
                            end
                        end
                        else if (add_full[SUM_W] == add_full[SUM_W-1]
                                 && add_full[SUM_W-1:0] != MISSING_SUM)
                        begin
                            wr_data = add_full[SUM_W-1:0];
                        end
                        else
                        begin
                            // The sum left the representable range or hit the MISSING_SUM code.
                            wr_data    = MISSING_SUM;
                            flag_after = 1'b1;
                        end
                    end
                    res_sum = wr_data;
                    res_ovf = flag_after;
                end
                CMD_READ_CLEAR:
                begin
                    wr_en      = 1'b1;
                    wr_data    = '0;
                    flag_after = 1'b0;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        mem_we    = clearing_reg || (s1_go && wr_en);
        mem_waddr = clearing_reg ? clr_addr_reg : s1_addr_reg;
        mem_wdata = clearing_reg ? '0 : wr_data;
    end

    always_comb
    begin
        group_count_next  = group_count_reg;
        drop_missing_next = drop_missing_reg;
        row_count_next    = row_count_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GROUP_COUNT:  group_count_next  = cfg_data[4:0];
                CFG_DROP_MISSING: drop_missing_next = cfg_data[0];
                CFG_ROW_COUNT:    row_count_next    = cfg_data[8:0];
                default:          group_count_next  = group_count_reg;
            endcase
        end
    end

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = in_acc ? 1'b1 : (s1_valid_reg && !s1_go);
        s1_cmd_next   = in_acc ? command : s1_cmd_reg;
        s1_bad_next   = in_acc ? in_bad : s1_bad_reg;
        s1_addr_next  = in_acc ? in_addr : s1_addr_reg;
        s1_value_next = in_acc ? value : s1_value_reg;
        s1_unit_next  = in_acc ? unit_value : s1_unit_reg;
        s1_last_next  = in_acc ? last_in_column : s1_last_reg;
        // A write on the same edge as this read is not seen by the RAM port.
        fwd_hit_next  = in_acc ? (mem_we && mem_waddr == in_addr) : fwd_hit_reg;
        fwd_data_next = in_acc ? mem_wdata : fwd_data_reg;
        ovf_flag_next = s1_go ? flag_after : ovf_flag_reg;
    end

    always_comb
    begin
        out_valid_next = s1_go ? 1'b1 : (out_valid_reg && out_stall);
        sum_next       = s1_go ? res_sum : sum_reg;
        ovf_out_next   = s1_go ? res_ovf : ovf_out_reg;
        bad_out_next   = s1_go ? s1_bad_reg : bad_out_reg;
        done_next      = s1_go ? s1_last_reg : done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg  <= GROUP_COUNT_RST;
            drop_missing_reg <= 1'b0;
            row_count_reg    <= ROW_COUNT_RST;
            clearing_reg     <= 1'b1;
            clr_addr_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            fwd_hit_reg      <= 1'b0;
            ovf_flag_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            group_count_reg  <= group_count_next;
            drop_missing_reg <= drop_missing_next;
            row_count_reg    <= row_count_next;
            clearing_reg     <= clearing_next;
            clr_addr_reg     <= clr_addr_next;
            s1_valid_reg     <= s1_valid_next;
            fwd_hit_reg      <= fwd_hit_next;
            ovf_flag_reg     <= ovf_flag_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg   <= s1_cmd_next;
        s1_bad_reg   <= s1_bad_next;
        s1_addr_reg  <= s1_addr_next;
        s1_value_reg <= s1_value_next;
        s1_unit_reg  <= s1_unit_next;
        s1_last_reg  <= s1_last_next;
        fwd_data_reg <= fwd_data_next;
        sum_reg      <= sum_next;
        ovf_out_reg  <= ovf_out_next;
        bad_out_reg  <= bad_out_next;
        done_reg     <= done_next;
    end

    assign out_valid     = out_valid_reg;
    assign sum           = sum_reg;
    assign overflow_seen = ovf_out_reg;
    assign bad_index     = bad_out_reg;
    assign column_done   = done_reg;

endmodule

@@ hdl/gscs_checker.sv @@
// Port-level checks for the grouped sparse column sum block, with its bind.
module gscs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] sum,
    input logic        bad_index
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // A word with a bad index reports a zero sum.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_index |-> sum == 32'd0)
        else $error("bad index word carries a nonzero sum");

    // A new result rises only for an accepted input word that went through stage one and the result register unstalled.
    a_rise_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result word without a matching input word");

endmodule

bind grouped_sparse_column_sum gscs_checker u_gscs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sum       (sum),
    .bad_index (bad_index)
);
